// ===== rtl/core/sfbp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfbp_pkg: shared types and constants of the song field bit packer
// Record opcodes, result kinds, field widths, and the bit chunk that travels
// from the classifier to the packing engine.
// ----------------------------------------------------------------------------
package sfbp_pkg;

    localparam int RAW_W     = 13;
    localparam int TRACK_W   = 6;
    localparam int NOTE_W    = 7;
    localparam int NIB_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 16;

    // Widest record is a track line: 3 flags + 7 + 4 + 4 + 8 bits.
    localparam int CHUNK_W   = 26;
    localparam int LEN_W     = 5;
    localparam int PEND_W    = 7;
    localparam int PCNT_W    = 3;
    localparam int ACC_W     = CHUNK_W + PEND_W;
    localparam int TOTAL_W   = 6;
    localparam int WORK_W    = 32;
    localparam int LEFT_W    = 3;

    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [3:0] RAW_MAX_WIDTH = 4'd13;

    typedef enum logic [2:0] {
        OP_RAW   = 3'd0,
        OP_SONG  = 3'd1,
        OP_INSTR = 3'd2,
        OP_TRACK = 3'd3,
        OP_ALIGN = 3'd4
    } sfbp_op_t;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_OFFSET = 1'b1;

    typedef struct packed {
        logic                is_align;
        logic [CHUNK_W-1:0]  bits;
        logic [LEN_W-1:0]    len;
    } sfbp_chunk_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0]  count;
        logic                full;
    } sfbp_qstat_t;

endpackage
`default_nettype wire

// ===== rtl/core/song_field_bit_packer.sv =====
`default_nettype none
// A taken record passes the chunk queue and then the output register. The output
// moves one word per cycle while out_stall is low; a record yields one to four words,
// or none, and the packing engine takes the next record as the last of these goes out.
// A two-entry chunk queue lets the input keep taking records while the output is stalled.
// Reset (rst_n, asynchronous, active low) empties the queue and clears the partial
// byte, its bit count and the running byte count.
// ----------------------------------------------------------------------------
// song_field_bit_packer: LSB-first bit packer for song records
// The front classifies each record into a bit chunk of up to 26 bits (or an
// align marker) and queues it. The back merges each chunk into the pending
// partial byte and sends full bytes, one word per cycle while not stalled,
// through an output register. Align flushes the partial byte with zero padding
// and then reports the byte count, which saturates at its all-ones value.
// ----------------------------------------------------------------------------
module song_field_bit_packer
    import sfbp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [2:0]          opcode,
    input  wire logic [RAW_W-1:0]    raw_value,
    input  wire logic [3:0]          raw_width,
    input  wire logic [TRACK_W-1:0]  track_num,
    input  wire logic [NIB_W-1:0]    transpose,
    input  wire logic [NOTE_W-1:0]   note,
    input  wire logic [NIB_W-1:0]    instrument,
    input  wire logic [BYTE_W-1:0]   command,
    input  wire logic [BYTE_W-1:0]   param,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     kind,
    output logic [CNT_W-1:0]         value,
    output logic                     last
);

    sfbp_chunk_t  front_chunk;
    logic         front_keep;
    logic         q_push;
    sfbp_chunk_t  q_head;
    logic         q_head_valid;
    logic         q_pop;
    sfbp_qstat_t  q_stat;

    // The classifier is combinational; a taken record enters the queue at
    // the same edge. Records that put no bits (unknown opcodes, empty raw
    // fields) are taken and simply not queued.
    sfbp_front u_front (
        .opcode      (opcode),
        .raw_value   (raw_value),
        .raw_width   (raw_width),
        .track_num   (track_num),
        .transpose   (transpose),
        .note        (note),
        .instrument  (instrument),
        .command     (command),
        .param       (param),
        .chunk       (front_chunk),
        .keep        (front_keep)
    );

    // The input stalls only while the queue is full, which depends on
    // registered state alone.
    assign in_stall = q_stat.full;
    assign q_push   = in_valid && !in_stall && front_keep;

    sfbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (front_chunk),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid),
        .stat       (q_stat)
    );

    // The packing engine pulls the next chunk in the cycle its last word
    // for the current one moves into the output register.
    sfbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .value      (value),
        .last       (last)
    );

`ifndef SYNTHESIS
    // A section offset always closes the words of its align record.
    a_offset_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_OFFSET) |-> last)
        else $error("section offset word without last");

    // A packed data word carries a single byte.
    a_data_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_DATA) |-> (value[CNT_W-1:BYTE_W] == '0))
        else $error("data word wider than a byte");

    // The engine never pulls from an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_stat.count != '0))
        else $error("chunk queue popped while empty");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/sfbp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfbp_front: record classifier
// Turns one input record into an LSB-first bit chunk with its length, or an
// align marker. Records that put no bits are dropped here.
// ----------------------------------------------------------------------------
module sfbp_front
    import sfbp_pkg::*;
(
    input  wire logic [2:0]          opcode,
    input  wire logic [RAW_W-1:0]    raw_value,
    input  wire logic [3:0]          raw_width,
    input  wire logic [TRACK_W-1:0]  track_num,
    input  wire logic [NIB_W-1:0]    transpose,
    input  wire logic [NOTE_W-1:0]   note,
    input  wire logic [NIB_W-1:0]    instrument,
    input  wire logic [BYTE_W-1:0]   command,
    input  wire logic [BYTE_W-1:0]   param,
    output sfbp_chunk_t              chunk,
    output logic                     keep
);

    logic [3:0]          raw_w;
    logic [RAW_W-1:0]    raw_mask;
    logic                has_tr;
    logic                has_note;
    logic                has_inst;
    logic [NIB_W-1:0]    cmd_id;
    logic                has_cmd;
    logic [CHUNK_W-1:0]  tl_bits;
    logic [LEN_W-1:0]    tl_pos;

    always_comb
    begin
        raw_w    = (raw_width > RAW_MAX_WIDTH) ? RAW_MAX_WIDTH : raw_width;
        raw_mask = ~({RAW_W{1'b1}} << raw_w);
        has_tr   = (transpose != '0);
        has_note = (note != '0);
        has_inst = (instrument != '0);
        cmd_id   = command[NIB_W-1:0];
        has_cmd  = (cmd_id != '0);
    end

    // Track line: three presence flags, then each present field in turn.
    always_comb
    begin
        tl_bits = {{(CHUNK_W-3){1'b0}}, has_cmd, has_inst, has_note};
        tl_pos  = LEN_W'(3);
        if (has_note)
        begin
            tl_bits = tl_bits | (CHUNK_W'(note) << tl_pos);
            tl_pos  = tl_pos + LEN_W'(NOTE_W);
        end
        if (has_inst)
        begin
            tl_bits = tl_bits | (CHUNK_W'(instrument) << tl_pos);
            tl_pos  = tl_pos + LEN_W'(NIB_W);
        end
        if (has_cmd)
        begin
            tl_bits = tl_bits | (CHUNK_W'(cmd_id) << tl_pos);
            tl_pos  = tl_pos + LEN_W'(NIB_W);
            tl_bits = tl_bits | (CHUNK_W'(param) << tl_pos);
            tl_pos  = tl_pos + LEN_W'(BYTE_W);
        end
    end

    always_comb
    begin
        chunk.is_align = 1'b0;
        chunk.bits     = '0;
        chunk.len      = '0;
        keep           = 1'b0;
        case (opcode)
            OP_RAW:
            begin
                chunk.bits = CHUNK_W'(raw_value & raw_mask);
                chunk.len  = LEN_W'(raw_w);
                keep       = (raw_w != '0);
            end
            OP_SONG:
            begin
                chunk.bits = CHUNK_W'({transpose & {NIB_W{has_tr}}, track_num, has_tr});
                chunk.len  = has_tr ? LEN_W'(1 + TRACK_W + NIB_W) : LEN_W'(1 + TRACK_W);
                keep       = 1'b1;
            end
            OP_INSTR:
            begin
                chunk.bits = CHUNK_W'({param, command});
                chunk.len  = LEN_W'(2 * BYTE_W);
                keep       = 1'b1;
            end
            OP_TRACK:
            begin
                chunk.bits = tl_bits;
                chunk.len  = tl_pos;
                keep       = 1'b1;
            end
            OP_ALIGN:
            begin
                chunk.is_align = 1'b1;
                keep           = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/sfbp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfbp_queue: chunk queue
// Small register FIFO between the classifier and the packing engine.
// ----------------------------------------------------------------------------
module sfbp_queue
    import sfbp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  sfbp_chunk_t       push_data,
    input  wire logic         pop,
    output sfbp_chunk_t       head,
    output logic              head_valid,
    output sfbp_qstat_t       stat
);

    sfbp_chunk_t          q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = q_mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));

endmodule
`default_nettype wire

// ===== rtl/core/sfbp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfbp_back: packing engine
// Merges each chunk into the pending partial byte, then sends the completed
// bytes, and for align the section offset, one word per cycle while the output is free.
// ----------------------------------------------------------------------------
module sfbp_back
    import sfbp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  sfbp_chunk_t       head,
    input  wire logic         head_valid,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic              kind,
    output logic [CNT_W-1:0]  value,
    output logic              last
);

    logic [PEND_W-1:0]   pend_bits_reg;
    logic [PEND_W-1:0]   pend_bits_next;
    logic [PCNT_W-1:0]   pend_cnt_reg;
    logic [PCNT_W-1:0]   pend_cnt_next;
    logic [WORK_W-1:0]   work_bytes_reg;
    logic [WORK_W-1:0]   work_bytes_next;
    logic [LEFT_W-1:0]   work_left_reg;
    logic [LEFT_W-1:0]   work_left_next;
    logic                work_off_reg;
    logic                work_off_next;
    logic [CNT_W-1:0]    byte_cnt_reg;
    logic [CNT_W-1:0]    byte_cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_kind_reg;
    logic                out_kind_next;
    logic [CNT_W-1:0]    out_value_reg;
    logic [CNT_W-1:0]    out_value_next;
    logic                out_last_reg;
    logic                out_last_next;

    logic                out_free;
    logic                work_busy;
    logic                emit;
    logic                emit_data;
    logic                emit_last;
    logic                load;
    logic [ACC_W-1:0]    acc;
    logic [ACC_W-1:0]    acc_rest;
    logic [TOTAL_W-1:0]  total;

    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        work_busy = (work_left_reg != '0) || work_off_reg;
        emit      = work_busy && out_free;
        emit_data = (work_left_reg != '0);
        emit_last = emit_data ? ((work_left_reg == LEFT_W'(1)) && !work_off_reg) : 1'b1;
        load      = head_valid && (!work_busy || (emit && emit_last));
    end

    // Merge the chunk above the pending bits; whole bytes go to the work
    // register and the leftover bits become the new partial byte.
    always_comb
    begin
        acc      = ACC_W'(pend_bits_reg) | (ACC_W'(head.bits) << pend_cnt_reg);
        total    = TOTAL_W'(pend_cnt_reg) + TOTAL_W'(head.len);
        acc_rest = acc >> {total[TOTAL_W-1:3], 3'b000};
    end

    always_comb
    begin
        pend_bits_next  = pend_bits_reg;
        pend_cnt_next   = pend_cnt_reg;
        work_bytes_next = work_bytes_reg;
        work_left_next  = work_left_reg;
        work_off_next   = work_off_reg;
        if (load)
        begin
            if (head.is_align)
            begin
                work_bytes_next = WORK_W'(pend_bits_reg);
                work_left_next  = (pend_cnt_reg != '0) ? LEFT_W'(1) : '0;
                work_off_next   = 1'b1;
                pend_bits_next  = '0;
                pend_cnt_next   = '0;
            end
            else
            begin
                work_bytes_next = acc[WORK_W-1:0];
                work_left_next  = total[TOTAL_W-1:3];
                work_off_next   = 1'b0;
                pend_bits_next  = acc_rest[PEND_W-1:0];
                pend_cnt_next   = total[PCNT_W-1:0];
            end
        end
        else if (emit)
        begin
            if (emit_data)
            begin
                work_bytes_next = work_bytes_reg >> BYTE_W;
                work_left_next  = work_left_reg - 1'b1;
            end
            else
            begin
                work_off_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        byte_cnt_next = byte_cnt_reg;
        if (emit && emit_data && (byte_cnt_reg != {CNT_W{1'b1}}))
        begin
            byte_cnt_next = byte_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        if (out_free)
        begin
            out_valid_next = emit;
            out_kind_next  = emit_data ? KIND_DATA : KIND_OFFSET;
            out_value_next = emit_data ? CNT_W'(work_bytes_reg[BYTE_W-1:0]) : byte_cnt_reg;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            work_left_reg <= '0;
            work_off_reg  <= 1'b0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            work_left_reg <= work_left_next;
            work_off_reg  <= work_off_next;
            byte_cnt_reg  <= byte_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_bytes_reg <= work_bytes_next;
        out_kind_reg   <= out_kind_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign pop       = load;
    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign value     = out_value_reg;
    assign last      = out_last_reg;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the song field bit packer
// Feeds raw fields, song entries, instrument steps, track lines, aligns and
// unused opcodes through the input channel. A behavioral packer in the bench
// predicts every output word, and the monitor checks each word against the
// oldest prediction under three stall profiles.
// ----------------------------------------------------------------------------
module tb;
    import sfbp_pkg::*;

    // Opcodes 5..7 have no record behind them. The block must drop them.
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    localparam logic [CNT_W-1:0] COUNT_CEIL = '1;

    // The worst honest gap is the forced receiver hold, so this is generous.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 96;

    // One input record, one field per port.
    typedef struct packed {
        logic [2:0]         op;
        logic [RAW_W-1:0]   raw_value;
        logic [3:0]         raw_width;
        logic [TRACK_W-1:0] track_num;
        logic [NIB_W-1:0]   transpose;
        logic [NOTE_W-1:0]  note;
        logic [NIB_W-1:0]   instrument;
        logic [BYTE_W-1:0]  command;
        logic [BYTE_W-1:0]  param;
    } song_rec_t;

    // One output word.
    typedef struct packed {
        logic             kind;
        logic [CNT_W-1:0] value;
        logic             last;
    } pack_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    song_rec_t offer = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic kind;
    logic [CNT_W-1:0] value;
    logic last;

    // Stimulus side: records waiting to be offered, and the bookkeeping that
    // lets the sequencer know when every record has been taken.
    song_rec_t pending_recs[$];
    int records_queued = 0;
    int records_taken = 0;

    // Prediction side: the bit accumulator, its fill level and the running
    // byte count, plus the words still owed by the block.
    logic [PEND_W-1:0] acc_bits = '0;
    logic [PCNT_W-1:0] acc_count = '0;
    logic [CNT_W-1:0] bytes_out = '0;
    pack_word_t record_words[$];
    pack_word_t expected_words[$];

    // Stall profiles, in percent of cycles.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // The sequencer asks for a long receiver hold by bumping hold_asks. The
    // monitor serves it and counts the hold down on its own.
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;

    int fail_count = 0;
    int data_checked = 0;
    int offsets_checked = 0;
    int quiet_cycles = 0;
    pack_word_t want_word;

    song_field_bit_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (offer.op),
        .raw_value   (offer.raw_value),
        .raw_width   (offer.raw_width),
        .track_num   (offer.track_num),
        .transpose   (offer.transpose),
        .note        (offer.note),
        .instrument  (offer.instrument),
        .command     (offer.command),
        .param       (offer.param),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .value       (value),
        .last        (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Behavioral packer
    // ------------------------------------------------------------------

    // A finished byte leaves as a data word. The count stops at its ceiling.
    task automatic emit_byte(input logic [7:0] b);
        record_words.push_back('{KIND_DATA, CNT_W'(b), 1'b0});
        if (bytes_out != COUNT_CEIL)
        begin
            bytes_out = bytes_out + 1'b1;
        end
        acc_bits = '0;
        acc_count = '0;
    endtask

    // Bits go in least significant first. The eighth bit completes a byte,
    // so it never needs to be stored in the seven-bit accumulator.
    task automatic shift_in_bits(input logic [15:0] data, input int nbits);
        for (int i = 0; i < nbits; i++)
        begin
            if (acc_count == 3'd7)
            begin
                emit_byte({data[i], acc_bits});
            end
            else
            begin
                acc_bits[acc_count] = data[i];
                acc_count = acc_count + 3'd1;
            end
        end
    endtask

    // Works out every word that one accepted record causes and queues them,
    // with last set on the final one.
    task automatic pack_record(input song_rec_t r);
        logic [3:0] w;
        logic [3:0] cmd_id;
        record_words.delete();
        cmd_id = r.command[3:0];
        case (r.op)
            OP_RAW:
            begin
                // Widths above the field size are clipped to it.
                w = (r.raw_width > RAW_MAX_WIDTH) ? RAW_MAX_WIDTH : r.raw_width;
                shift_in_bits(16'(r.raw_value), int'(w));
            end
            OP_SONG:
            begin
                shift_in_bits(16'(r.transpose != '0), 1);
                shift_in_bits(16'(r.track_num), TRACK_W);
                if (r.transpose != '0)
                begin
                    shift_in_bits(16'(r.transpose), NIB_W);
                end
            end
            OP_INSTR:
            begin
                shift_in_bits(16'(r.command), BYTE_W);
                shift_in_bits(16'(r.param), BYTE_W);
            end
            OP_TRACK:
            begin
                // Three presence flags come first, then the present parts.
                shift_in_bits(16'(r.note != '0), 1);
                shift_in_bits(16'(r.instrument != '0), 1);
                shift_in_bits(16'(cmd_id != '0), 1);
                if (r.note != '0)
                begin
                    shift_in_bits(16'(r.note), NOTE_W);
                end
                if (r.instrument != '0)
                begin
                    shift_in_bits(16'(r.instrument), NIB_W);
                end
                if (cmd_id != '0)
                begin
                    shift_in_bits(16'(cmd_id), NIB_W);
                    shift_in_bits(16'(r.param), BYTE_W);
                end
            end
            OP_ALIGN:
            begin
                // A partial byte is flushed with zero padding on top; an
                // empty accumulator yields only the offset word.
                if (acc_count != '0)
                begin
                    emit_byte({1'b0, acc_bits});
                end
                record_words.push_back('{KIND_OFFSET, bytes_out, 1'b0});
            end
            default:
            begin
                // Unused opcodes leave no trace.
            end
        endcase
        for (int i = 0; i < record_words.size(); i++)
        begin
            want_word = record_words[i];
            want_word.last = (i == record_words.size() - 1);
            expected_words.push_back(want_word);
        end
    endtask

    // ------------------------------------------------------------------
    // Record builders
    // ------------------------------------------------------------------

    function automatic song_rec_t mk_rec(
        input logic [2:0]         op,
        input logic [RAW_W-1:0]   rv,
        input logic [3:0]         rw,
        input logic [TRACK_W-1:0] trk,
        input logic [NIB_W-1:0]   tp,
        input logic [NOTE_W-1:0]  nt,
        input logic [NIB_W-1:0]   ins,
        input logic [BYTE_W-1:0]  cmd,
        input logic [BYTE_W-1:0]  prm
    );
        song_rec_t r;
        r.op = op;
        r.raw_value = rv;
        r.raw_width = rw;
        r.track_num = trk;
        r.transpose = tp;
        r.note = nt;
        r.instrument = ins;
        r.command = cmd;
        r.param = prm;
        return r;
    endfunction

    // Mostly real records, some aligns, a few unused opcodes. Optional parts
    // are forced absent a quarter of the time so both encodings show up often.
    function automatic song_rec_t random_rec();
        song_rec_t r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            r.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        else if (pick < 20)
        begin
            r.op = OP_ALIGN;
        end
        else
        begin
            r.op = 3'($urandom_range(OP_RAW, OP_TRACK));
        end
        r.raw_value = RAW_W'($urandom_range(0, 8191));
        r.raw_width = 4'($urandom_range(0, 15));
        r.track_num = TRACK_W'($urandom_range(0, 63));
        r.transpose = NIB_W'($urandom_range(0, 15));
        r.note = NOTE_W'($urandom_range(0, 127));
        r.instrument = NIB_W'($urandom_range(0, 15));
        r.command = BYTE_W'($urandom_range(0, 255));
        r.param = BYTE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
        begin
            r.transpose = '0;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            r.note = '0;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            r.instrument = '0;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            r.command[3:0] = '0;
        end
        return r;
    endfunction

    task automatic queue_rec(input song_rec_t r);
        pending_recs.push_back(r);
        records_queued++;
    endtask

    // The sender stops offering once its queue is empty; this waits for the
    // last record to be taken and its words to come back.
    task automatic wait_drained();
        while (records_taken != records_queued || expected_words.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued records. A record on offer stays put until it
    // is taken; only then may the next one go out, or a gap be inserted.
    // Valid is decided by the idle draw and the pending queue, never by in_stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            offer <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pack_record(offer);
                records_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_recs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    offer <= pending_recs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every word taken from the output against the oldest
    // prediction, and drives out_stall, including the long forced hold.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: kind %0d value %0h last %0d", kind, value, last);
                    fail_count++;
                end
                else
                begin
                    want_word = expected_words.pop_front();
                    if (kind !== want_word.kind)
                    begin
                        $error("kind mismatch: expected %0d, actual %0d", want_word.kind, kind);
                        fail_count++;
                    end
                    if (value !== want_word.value)
                    begin
                        $error("value mismatch: expected %0h, actual %0h",
                               want_word.value, value);
                        fail_count++;
                    end
                    if (last !== want_word.last)
                    begin
                        $error("last mismatch: expected %0d, actual %0d", want_word.last, last);
                        fail_count++;
                    end
                    if (want_word.kind == KIND_OFFSET)
                    begin
                        offsets_checked++;
                    end
                    else
                    begin
                        data_checked++;
                    end
                end
            end
            if (hold_served != hold_asks)
            begin
                hold_served = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any accepted word on either side counts as progress.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles, %0d words still owed",
                         quiet_cycles, expected_words.size());
                $display("Simulation FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: directed records, then three random phases with different
    // stall profiles.
    // ------------------------------------------------------------------
    initial
    begin
        send_idle_pct = 28;
        recv_idle_pct = 47;

        // Directed: field extremes, every record type, clipping, empty raw
        // field, no presence flag, each flag alone and all flags, both align cases, unused opcodes.
        queue_rec(mk_rec(OP_RAW, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_RAW, 8191, 13, 0, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_RAW, 8191, 15, 63, 15, 127, 15, 255, 255));
        queue_rec(mk_rec(OP_RAW, 13'h1555, 14, 0, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_SONG, 0, 0, 63, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_SONG, 0, 0, 0, 15, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_SONG, 0, 0, 42, 9, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_INSTR, 0, 0, 0, 0, 0, 0, 255, 255));
        queue_rec(mk_rec(OP_INSTR, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_TRACK, 0, 0, 0, 0, 0, 0, 8'hF0, 255));
        queue_rec(mk_rec(OP_TRACK, 0, 0, 0, 0, 127, 15, 255, 255));
        queue_rec(mk_rec(OP_TRACK, 0, 0, 0, 0, 1, 0, 0, 0));
        queue_rec(mk_rec(OP_TRACK, 0, 0, 0, 0, 0, 8, 0, 0));
        queue_rec(mk_rec(OP_TRACK, 0, 0, 0, 0, 0, 0, 8'h01, 8'h80));
        queue_rec(mk_rec(OP_ALIGN, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_ALIGN, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_UNUSED_LO, 8191, 15, 63, 15, 127, 15, 255, 255));
        queue_rec(mk_rec(OP_UNUSED_LO + 3'd1, 8191, 13, 63, 15, 127, 15, 255, 255));
        queue_rec(mk_rec(OP_UNUSED_HI, 8191, 15, 63, 15, 127, 15, 255, 255));
        queue_rec(mk_rec(OP_RAW, 1, 1, 0, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_ALIGN, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_RAW, 8'hAA, 8, 0, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_ALIGN, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Phase one: sender idles lightly, receiver heavily. A long receiver
        // hold lands while records are still queued, so the chunk queue fills
        // and the input side has to stall.
        repeat (80) queue_rec(random_rec());
        hold_asks++;
        wait_drained();

        // Phase two: the profiles swap. The sender sat idle above until every
        // word was back, so this phase starts from an empty pipeline.
        send_idle_pct = 47;
        recv_idle_pct = 28;
        repeat (80) queue_rec(random_rec());
        wait_drained();

        // Phase three: back to back on both sides, closed by a short raw
        // field and aligns so the final offsets are checked.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (34) queue_rec(random_rec());
        queue_rec(mk_rec(OP_ALIGN, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_RAW, 5, 3, 0, 0, 0, 0, 0, 0));
        queue_rec(mk_rec(OP_ALIGN, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // Keep clocking a while so that any stray word after the last one shows.
        repeat (8) @(posedge clk);

        $display("Run covered %0d records: %0d data bytes and %0d section offsets checked.",
                 records_taken, data_checked, offsets_checked);
        $display("Three stall profiles were used, with one long output hold.");
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
